FILE: rtl/prst_pkg.sv
// Shared types and constants for the point rotate/scale/translate core.
// Used by every module under rtl/; depends on nothing.
package prst_pkg;

	// fixed field widths of the channels and the register file
	localparam int FIELD_W     = 21;
	localparam int SLOT_W      = 21;
	localparam int PACK_W      = 63;
	localparam int TRIG_W      = 21;
	localparam int FACTOR_W    = 20;
	localparam int CFG_IDX_W   = 3;

	// fraction bits dropped after each product
	localparam int AXIS_FRAC   = 19;
	localparam int FACTOR_FRAC = 12;

	// low part of the axis-scale gain multiplied on its own
	localparam int GAIN_LO_W   = 18;

	// register stages from input to output register
	localparam int NUM_STAGES  = 7;

	typedef enum logic [1:0] {
		MODE_TRANSLATE  = 2'd0,
		MODE_ROTATE     = 2'd1,
		MODE_UNI_SCALE  = 2'd2,
		MODE_AXIS_SCALE = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE   = 3'd0,
		REG_PIVOT  = 3'd1,
		REG_AXIS   = 3'd2,
		REG_OFFSET = 3'd3,
		REG_COSINE = 3'd4,
		REG_SINE   = 3'd5,
		REG_FACTOR = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		mode_t               mode;
		logic [PACK_W-1:0]   pivot;
		logic [PACK_W-1:0]   axis;
		logic [PACK_W-1:0]   offset;
		logic [TRIG_W-1:0]   cosine;
		logic [TRIG_W-1:0]   sine;
		logic [FACTOR_W-1:0] factor;
	} cfg_t;

	// 1.0 in each fixed-point format
	localparam logic [PACK_W-1:0]   AXIS_RESET   = 63'd524288;
	localparam logic [TRIG_W-1:0]   COS_RESET    = 21'd524288;
	localparam logic [FACTOR_W-1:0] FACTOR_RESET = 20'd4096;

endpackage

FILE: rtl/prst_flow.sv
// Valid chain and per-stage load enables for the transform pipeline.
// Depends on prst_pkg (stage count).
module prst_flow (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [prst_pkg::NUM_STAGES-1:0]  stage_en
);

	localparam int N = prst_pkg::NUM_STAGES;

	logic [N-1:0] vld_q;

	// a stage loads when it is empty or when the stage after it loads too
	always_comb begin
		stage_en[N-1] = !vld_q[N-1] || out_ready;
		for (int k = N - 2; k >= 0; k--) begin
			stage_en[k] = !vld_q[k] || stage_en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (stage_en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < N; k++) begin
				if (stage_en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = stage_en[0];
	assign out_valid = vld_q[N-1];

endmodule

FILE: rtl/prst_front.sv
// Stages 1-3: offset from pivot, first products, dot and cross sums.
// Depends on prst_pkg (widths, cfg_t).
module prst_front #(
	parameter int COORD_WIDTH = 21,
	localparam int OFF_W = COORD_WIDTH + 1,
	localparam int AO_W  = prst_pkg::SLOT_W + OFF_W,
	localparam int DOT_W = AO_W + 2,
	localparam int DT_W  = DOT_W - prst_pkg::AXIS_FRAC,
	localparam int CRD_W = AO_W + 1,
	localparam int CR_W  = CRD_W - prst_pkg::AXIS_FRAC,
	localparam int OCS_P = OFF_W + prst_pkg::TRIG_W,
	localparam int OCS_W = OCS_P - prst_pkg::AXIS_FRAC,
	localparam int OF_P  = OFF_W + prst_pkg::FACTOR_W + 1,
	localparam int OF_W  = OF_P - prst_pkg::FACTOR_FRAC
) (
	input  logic                                clk,
	input  logic [2:0]                          stage_en,
	input  prst_pkg::cfg_t                      cfg,
	input  logic [prst_pkg::FIELD_W-1:0]        point_x,
	input  logic [prst_pkg::FIELD_W-1:0]        point_y,
	input  logic [prst_pkg::FIELD_W-1:0]        point_z,
	output logic signed [DT_W-1:0]              dt_s3,
	output logic signed [CR_W-1:0]              cr_s3  [3],
	output logic signed [OCS_W-1:0]             ocs_s3 [3],
	output logic signed [OF_W-1:0]              of_s3  [3],
	output logic signed [OFF_W-1:0]             off_s3 [3],
	output logic signed [OFF_W-1:0]             tr_s3  [3]
);

	localparam int W = COORD_WIDTH;

	logic signed [W-1:0]                    pin [3];
	logic signed [W-1:0]                    pv  [3];
	logic signed [W-1:0]                    tv  [3];
	logic signed [prst_pkg::SLOT_W-1:0]     ax  [3];
	logic signed [prst_pkg::TRIG_W-1:0]     cs;
	logic signed [prst_pkg::FACTOR_W:0]     fs;

	logic signed [OFF_W-1:0] off_s1 [3];
	logic signed [OFF_W-1:0] tr_s1  [3];

	logic signed [AO_W-1:0]  ao     [3][3];
	logic signed [OCS_P-1:0] ocs_p  [3];
	logic signed [OF_P-1:0]  of_p   [3];
	logic signed [AO_W-1:0]  ao_s2  [3][3];
	logic signed [OCS_W-1:0] ocs_s2 [3];
	logic signed [OF_W-1:0]  of_s2  [3];
	logic signed [OFF_W-1:0] off_s2 [3];
	logic signed [OFF_W-1:0] tr_s2  [3];

	logic signed [DOT_W-1:0] dot;
	logic signed [CRD_W-1:0] crd [3];

	assign pin[0] = $signed(point_x[W-1:0]);
	assign pin[1] = $signed(point_y[W-1:0]);
	assign pin[2] = $signed(point_z[W-1:0]);
	assign cs     = $signed(cfg.cosine);
	assign fs     = $signed({1'b0, cfg.factor});

	// slot 0 is x in the top bits of each packed register
	for (genvar i = 0; i < 3; i++) begin : g_slot
		assign pv[i] = $signed(cfg.pivot[(2-i)*prst_pkg::SLOT_W +: W]);
		assign tv[i] = $signed(cfg.offset[(2-i)*prst_pkg::SLOT_W +: W]);
		assign ax[i] = $signed(cfg.axis[(2-i)*prst_pkg::SLOT_W +: prst_pkg::SLOT_W]);
	end

	// stage 1: offset from the pivot and the translated point
	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			for (int i = 0; i < 3; i++) begin
				off_s1[i] <= OFF_W'(pin[i]) - OFF_W'(pv[i]);
				tr_s1[i]  <= OFF_W'(pin[i]) + OFF_W'(tv[i]);
			end
		end
	end

	// stage 2: all axis-by-offset products, offset by cosine and by factor
	for (genvar i = 0; i < 3; i++) begin : g_prod
		for (genvar j = 0; j < 3; j++) begin : g_col
			assign ao[i][j] = ax[i] * off_s1[j];
		end
		assign ocs_p[i] = off_s1[i] * cs;
		assign of_p[i]  = off_s1[i] * fs;
	end

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					ao_s2[i][j] <= ao[i][j];
				end
				ocs_s2[i] <= ocs_p[i][OCS_P-1:prst_pkg::AXIS_FRAC];
				of_s2[i]  <= of_p[i][OF_P-1:prst_pkg::FACTOR_FRAC];
				off_s2[i] <= off_s1[i];
				tr_s2[i]  <= tr_s1[i];
			end
		end
	end

	// stage 3: dot product and cross product, truncated
	assign dot    = ao_s2[0][0] + ao_s2[1][1] + ao_s2[2][2];
	assign crd[0] = ao_s2[1][2] - ao_s2[2][1];
	assign crd[1] = ao_s2[2][0] - ao_s2[0][2];
	assign crd[2] = ao_s2[0][1] - ao_s2[1][0];

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			dt_s3 <= dot[DOT_W-1:prst_pkg::AXIS_FRAC];
			for (int i = 0; i < 3; i++) begin
				cr_s3[i]  <= crd[i][CRD_W-1:prst_pkg::AXIS_FRAC];
				ocs_s3[i] <= ocs_s2[i];
				of_s3[i]  <= of_s2[i];
				off_s3[i] <= off_s2[i];
				tr_s3[i]  <= tr_s2[i];
			end
		end
	end

endmodule

FILE: rtl/prst_mid.sv
// Stages 4-5: scalar gains from the dot product, sine term, mode base,
// and the per-axis gain products. Depends on prst_pkg (widths, cfg_t, mode_t).
module prst_mid #(
	parameter int COORD_WIDTH = 21,
	localparam int OFF_W  = COORD_WIDTH + 1,
	localparam int DT_W   = prst_pkg::SLOT_W + OFF_W + 2 - prst_pkg::AXIS_FRAC,
	localparam int CR_W   = prst_pkg::SLOT_W + OFF_W + 1 - prst_pkg::AXIS_FRAC,
	localparam int OCS_W  = OFF_W + prst_pkg::TRIG_W - prst_pkg::AXIS_FRAC,
	localparam int OF_W   = OFF_W + prst_pkg::FACTOR_W + 1 - prst_pkg::FACTOR_FRAC,
	localparam int OMC_W  = prst_pkg::TRIG_W + 1,
	localparam int FM_W   = prst_pkg::FACTOR_W + 1,
	localparam int DK_W   = DT_W + OMC_W - prst_pkg::AXIS_FRAC,
	localparam int K_W    = DT_W + FM_W - prst_pkg::FACTOR_FRAC,
	localparam int KL_W   = prst_pkg::GAIN_LO_W,
	localparam int KH_W   = K_W - KL_W,
	localparam int CSN_P  = CR_W + prst_pkg::TRIG_W,
	localparam int CSN_W  = CSN_P - prst_pkg::AXIS_FRAC,
	localparam int ADK_P  = prst_pkg::SLOT_W + DK_W,
	localparam int ADK_W  = ADK_P - prst_pkg::AXIS_FRAC,
	localparam int AKH_W  = prst_pkg::SLOT_W + KH_W,
	localparam int AKL_W  = prst_pkg::SLOT_W + KL_W + 1,
	localparam int AKT_W  = prst_pkg::SLOT_W + K_W + 1 - prst_pkg::AXIS_FRAC,
	localparam int R_W    = AKT_W + 2
) (
	input  logic                     clk,
	input  logic [1:0]               stage_en,
	input  prst_pkg::cfg_t           cfg,
	input  logic signed [DT_W-1:0]   dt_s3,
	input  logic signed [CR_W-1:0]   cr_s3  [3],
	input  logic signed [OCS_W-1:0]  ocs_s3 [3],
	input  logic signed [OF_W-1:0]   of_s3  [3],
	input  logic signed [OFF_W-1:0]  off_s3 [3],
	input  logic signed [OFF_W-1:0]  tr_s3  [3],
	output logic signed [ADK_W-1:0]  adk_s5  [3],
	output logic signed [AKH_W-1:0]  akh_s5  [3],
	output logic signed [AKL_W-1:0]  akl_s5  [3],
	output logic signed [R_W-1:0]    base_s5 [3]
);

	localparam int W     = COORD_WIDTH;
	localparam int DKP_W = DT_W + OMC_W;
	localparam int KP_W  = DT_W + FM_W;
	localparam logic signed [OMC_W-1:0] ONE_Q19 = OMC_W'(1 << prst_pkg::AXIS_FRAC);
	localparam logic signed [FM_W-1:0]  ONE_Q12 = FM_W'(1 << prst_pkg::FACTOR_FRAC);

	logic signed [W-1:0]                 pv [3];
	logic signed [prst_pkg::SLOT_W-1:0]  ax [3];
	logic signed [prst_pkg::TRIG_W-1:0]  cs;
	logic signed [prst_pkg::TRIG_W-1:0]  sn;
	logic signed [OMC_W-1:0]             omc;
	logic signed [FM_W-1:0]              fm;

	logic signed [DKP_W-1:0] dkp;
	logic signed [KP_W-1:0]  kp;
	logic signed [CSN_P-1:0] csn_p  [3];
	logic signed [R_W-1:0]   base_p [3];

	logic signed [DK_W-1:0]  dk_s4;
	logic signed [K_W-1:0]   k_s4;
	logic signed [CSN_W-1:0] csn_s4  [3];
	logic signed [R_W-1:0]   base_s4 [3];

	logic signed [KH_W-1:0]  khi;
	logic signed [KL_W:0]    klo;
	logic signed [ADK_P-1:0] adk_p [3];
	logic signed [AKH_W-1:0] akh_p [3];
	logic signed [AKL_W-1:0] akl_p [3];
	logic signed [R_W-1:0]   csn_add [3];

	assign cs  = $signed(cfg.cosine);
	assign sn  = $signed(cfg.sine);
	assign omc = ONE_Q19 - OMC_W'(cs);
	assign fm  = $signed({1'b0, cfg.factor}) - ONE_Q12;

	for (genvar i = 0; i < 3; i++) begin : g_slot
		assign pv[i] = $signed(cfg.pivot[(2-i)*prst_pkg::SLOT_W +: W]);
		assign ax[i] = $signed(cfg.axis[(2-i)*prst_pkg::SLOT_W +: prst_pkg::SLOT_W]);
	end

	// stage 4: dot-product gains, sine term, base term of each mode
	assign dkp = dt_s3 * omc;
	assign kp  = dt_s3 * fm;

	for (genvar i = 0; i < 3; i++) begin : g_sine
		assign csn_p[i] = cr_s3[i] * sn;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			case (cfg.mode)
				prst_pkg::MODE_TRANSLATE:  base_p[i] = R_W'(tr_s3[i]);
				prst_pkg::MODE_ROTATE:     base_p[i] = R_W'(pv[i]) + R_W'(ocs_s3[i]);
				prst_pkg::MODE_UNI_SCALE:  base_p[i] = R_W'(pv[i]) + R_W'(of_s3[i]);
				prst_pkg::MODE_AXIS_SCALE: base_p[i] = R_W'(pv[i]) + R_W'(off_s3[i]);
				default:                   base_p[i] = R_W'(tr_s3[i]);
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			dk_s4 <= dkp[DKP_W-1:prst_pkg::AXIS_FRAC];
			k_s4  <= kp[KP_W-1:prst_pkg::FACTOR_FRAC];
			for (int i = 0; i < 3; i++) begin
				csn_s4[i]  <= csn_p[i][CSN_P-1:prst_pkg::AXIS_FRAC];
				base_s4[i] <= base_p[i];
			end
		end
	end

	// stage 5: axis times gain; the wide axis-scale gain is split into high and low parts
	assign khi = $signed(k_s4[K_W-1:KL_W]);
	assign klo = $signed({1'b0, k_s4[KL_W-1:0]});

	for (genvar i = 0; i < 3; i++) begin : g_gain
		assign adk_p[i]   = ax[i] * dk_s4;
		assign akh_p[i]   = ax[i] * khi;
		assign akl_p[i]   = ax[i] * klo;
		assign csn_add[i] = (cfg.mode == prst_pkg::MODE_ROTATE) ? R_W'(csn_s4[i])
		                                                         : R_W'(0);
	end

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			for (int i = 0; i < 3; i++) begin
				adk_s5[i]  <= adk_p[i][ADK_P-1:prst_pkg::AXIS_FRAC];
				akh_s5[i]  <= akh_p[i];
				akl_s5[i]  <= akl_p[i];
				base_s5[i] <= base_s4[i] + csn_add[i];
			end
		end
	end

endmodule

FILE: rtl/prst_back.sv
// Stages 6-7: recombine the axis term, final sum, saturate to the coordinate range.
// Depends on prst_pkg (widths, mode_t).
module prst_back #(
	parameter int COORD_WIDTH = 21,
	localparam int OFF_W  = COORD_WIDTH + 1,
	localparam int DT_W   = prst_pkg::SLOT_W + OFF_W + 2 - prst_pkg::AXIS_FRAC,
	localparam int DK_W   = DT_W + prst_pkg::TRIG_W + 1 - prst_pkg::AXIS_FRAC,
	localparam int K_W    = DT_W + prst_pkg::FACTOR_W + 1 - prst_pkg::FACTOR_FRAC,
	localparam int KL_W   = prst_pkg::GAIN_LO_W,
	localparam int KH_W   = K_W - KL_W,
	localparam int ADK_W  = prst_pkg::SLOT_W + DK_W - prst_pkg::AXIS_FRAC,
	localparam int AKH_W  = prst_pkg::SLOT_W + KH_W,
	localparam int AKL_W  = prst_pkg::SLOT_W + KL_W + 1,
	localparam int AK_W   = prst_pkg::SLOT_W + K_W + 1,
	localparam int AKT_W  = AK_W - prst_pkg::AXIS_FRAC,
	localparam int R_W    = AKT_W + 2
) (
	input  logic                            clk,
	input  logic [1:0]                      stage_en,
	input  prst_pkg::mode_t                 mode,
	input  logic signed [ADK_W-1:0]         adk_s5  [3],
	input  logic signed [AKH_W-1:0]         akh_s5  [3],
	input  logic signed [AKL_W-1:0]         akl_s5  [3],
	input  logic signed [R_W-1:0]           base_s5 [3],
	output logic [prst_pkg::FIELD_W-1:0]    moved_s7 [3],
	output logic                            sat_s7
);

	localparam int W = COORD_WIDTH;
	localparam logic signed [R_W-1:0] MAXV = $signed({{(R_W-W+1){1'b0}}, {(W-1){1'b1}}});
	localparam logic signed [R_W-1:0] MINV = ~MAXV;

	logic signed [AK_W-1:0]  aksum  [3];
	logic signed [AKT_W-1:0] term_p [3];
	logic signed [AKT_W-1:0] term_s6 [3];
	logic signed [R_W-1:0]   base_s6 [3];
	logic signed [R_W-1:0]   r      [3];
	logic signed [W-1:0]     cl     [3];
	logic [2:0]              sat_v;

	// stage 6: select the axis term of the active mode
	for (genvar i = 0; i < 3; i++) begin : g_term
		assign aksum[i] = (AK_W'(akh_s5[i]) <<< KL_W) + AK_W'(akl_s5[i]);
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			case (mode)
				prst_pkg::MODE_ROTATE:     term_p[i] = AKT_W'(adk_s5[i]);
				prst_pkg::MODE_AXIS_SCALE: term_p[i] = aksum[i][AK_W-1:prst_pkg::AXIS_FRAC];
				default:                   term_p[i] = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			for (int i = 0; i < 3; i++) begin
				term_s6[i] <= term_p[i];
				base_s6[i] <= base_s5[i];
			end
		end
	end

	// stage 7: final sum and clamp
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			r[i]     = base_s6[i] + R_W'(term_s6[i]);
			cl[i]    = r[i][W-1:0];
			sat_v[i] = 1'b0;
			if (r[i] > MAXV) begin
				cl[i]    = MAXV[W-1:0];
				sat_v[i] = 1'b1;
			end else if (r[i] < MINV) begin
				cl[i]    = MINV[W-1:0];
				sat_v[i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			for (int i = 0; i < 3; i++) begin
				moved_s7[i] <= prst_pkg::FIELD_W'(cl[i]);
			end
			sat_s7 <= |sat_v;
		end
	end

endmodule

FILE: rtl/point_rotate_scale_translate_core.sv
// Top level of the point rotate/scale/translate core: register file, pipeline
// flow control and the three datapath sections. Depends on prst_pkg,
// prst_flow, prst_front, prst_mid and prst_back.
//
// Usage:
//   Input channel (in_valid/in_ready, point_x/y/z) takes one Q10.10 point per
//   transaction; output channel (out_valid/out_ready, moved_x/y/z, saturated)
//   returns one transformed point per input, in order.
//   The register file is written through cfg_wr_en/cfg_wr_idx/cfg_wr_data, one
//   register per cycle, with no handshake and no read-back. Write it only while
//   the pipeline is empty; indexes beyond the register list are dropped.
// Timing:
//   Seven register stages. A point accepted into stage 1 passes through
//   the stages in order and can leave from stage 7, the output register.
//   One point per clock is sustained unless out_ready is low: every
//   multiplier has its own pipeline register, so points share nothing.
// Stalls:
//   Each stage advances when it is empty or the stage after it advances, so
//   holding out_ready low fills the bubbles first; in_ready drops only when
//   all seven stages hold a point. Nothing is dropped or duplicated.
// Reset:
//   arst_n clears all valid bits and loads the registers with translate mode,
//   zero pivot and offset, axis (0,0,1), cosine 1.0, sine 0 and factor 1.0.
module point_rotate_scale_translate_core #(
	parameter int COORD_WIDTH = 21
) (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               cfg_wr_en,
	input  logic [prst_pkg::CFG_IDX_W-1:0]     cfg_wr_idx,
	input  logic [prst_pkg::PACK_W-1:0]        cfg_wr_data,

	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [prst_pkg::FIELD_W-1:0]       point_x,
	input  logic [prst_pkg::FIELD_W-1:0]       point_y,
	input  logic [prst_pkg::FIELD_W-1:0]       point_z,

	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [prst_pkg::FIELD_W-1:0]       moved_x,
	output logic [prst_pkg::FIELD_W-1:0]       moved_y,
	output logic [prst_pkg::FIELD_W-1:0]       moved_z,
	output logic                               saturated
);

	localparam int W      = COORD_WIDTH;
	localparam int FW     = prst_pkg::FIELD_W;
	localparam int OFF_W  = W + 1;
	localparam int DT_W   = prst_pkg::SLOT_W + OFF_W + 2 - prst_pkg::AXIS_FRAC;
	localparam int CR_W   = prst_pkg::SLOT_W + OFF_W + 1 - prst_pkg::AXIS_FRAC;
	localparam int OCS_W  = OFF_W + prst_pkg::TRIG_W - prst_pkg::AXIS_FRAC;
	localparam int OF_W   = OFF_W + prst_pkg::FACTOR_W + 1 - prst_pkg::FACTOR_FRAC;
	localparam int DK_W   = DT_W + prst_pkg::TRIG_W + 1 - prst_pkg::AXIS_FRAC;
	localparam int K_W    = DT_W + prst_pkg::FACTOR_W + 1 - prst_pkg::FACTOR_FRAC;
	localparam int KH_W   = K_W - prst_pkg::GAIN_LO_W;
	localparam int ADK_W  = prst_pkg::SLOT_W + DK_W - prst_pkg::AXIS_FRAC;
	localparam int AKH_W  = prst_pkg::SLOT_W + KH_W;
	localparam int AKL_W  = prst_pkg::SLOT_W + prst_pkg::GAIN_LO_W + 1;
	localparam int AKT_W  = prst_pkg::SLOT_W + K_W + 1 - prst_pkg::AXIS_FRAC;
	localparam int R_W    = AKT_W + 2;

	prst_pkg::cfg_t cfg_q;

	logic [prst_pkg::NUM_STAGES-1:0] stage_en;

	logic signed [DT_W-1:0]  dt_s3;
	logic signed [CR_W-1:0]  cr_s3   [3];
	logic signed [OCS_W-1:0] ocs_s3  [3];
	logic signed [OF_W-1:0]  of_s3   [3];
	logic signed [OFF_W-1:0] off_s3  [3];
	logic signed [OFF_W-1:0] tr_s3   [3];
	logic signed [ADK_W-1:0] adk_s5  [3];
	logic signed [AKH_W-1:0] akh_s5  [3];
	logic signed [AKL_W-1:0] akl_s5  [3];
	logic signed [R_W-1:0]   base_s5 [3];
	logic [FW-1:0]           moved_s7 [3];
	logic                    sat_s7;

	// ---------------------------------------------------------------------
	// Register file. The user must write it only while the pipeline is empty;
	// the block does not enforce this. Stages read it with no per-point copy.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode   <= prst_pkg::MODE_TRANSLATE;
			cfg_q.pivot  <= '0;
			cfg_q.axis   <= prst_pkg::AXIS_RESET;
			cfg_q.offset <= '0;
			cfg_q.cosine <= prst_pkg::COS_RESET;
			cfg_q.sine   <= '0;
			cfg_q.factor <= prst_pkg::FACTOR_RESET;
		end else if (cfg_wr_en) begin
			case (prst_pkg::cfg_idx_t'(cfg_wr_idx))
				prst_pkg::REG_MODE:   cfg_q.mode   <= prst_pkg::mode_t'(cfg_wr_data[1:0]);
				prst_pkg::REG_PIVOT:  cfg_q.pivot  <= cfg_wr_data;
				prst_pkg::REG_AXIS:   cfg_q.axis   <= cfg_wr_data;
				prst_pkg::REG_OFFSET: cfg_q.offset <= cfg_wr_data;
				prst_pkg::REG_COSINE: cfg_q.cosine <= cfg_wr_data[prst_pkg::TRIG_W-1:0];
				prst_pkg::REG_SINE:   cfg_q.sine   <= cfg_wr_data[prst_pkg::TRIG_W-1:0];
				prst_pkg::REG_FACTOR: cfg_q.factor <= cfg_wr_data[prst_pkg::FACTOR_W-1:0];
				default: ;  // drop writes to unused indexes
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Flow control: one valid bit per stage, bubbles collapse on a stall.
	// ---------------------------------------------------------------------
	prst_flow u_flow (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stage_en  (stage_en)
	);

	// Stages 1-3: offset, first products, dot and cross sums
	prst_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk      (clk),
		.stage_en (stage_en[2:0]),
		.cfg      (cfg_q),
		.point_x  (point_x),
		.point_y  (point_y),
		.point_z  (point_z),
		.dt_s3    (dt_s3),
		.cr_s3    (cr_s3),
		.ocs_s3   (ocs_s3),
		.of_s3    (of_s3),
		.off_s3   (off_s3),
		.tr_s3    (tr_s3)
	);

	// Stages 4-5: rotation and stretch gains, sine term, mode base
	prst_mid #(.COORD_WIDTH(COORD_WIDTH)) u_mid (
		.clk      (clk),
		.stage_en (stage_en[4:3]),
		.cfg      (cfg_q),
		.dt_s3    (dt_s3),
		.cr_s3    (cr_s3),
		.ocs_s3   (ocs_s3),
		.of_s3    (of_s3),
		.off_s3   (off_s3),
		.tr_s3    (tr_s3),
		.adk_s5   (adk_s5),
		.akh_s5   (akh_s5),
		.akl_s5   (akl_s5),
		.base_s5  (base_s5)
	);

	// Stages 6-7: axis term, final sum, clamp into the output register
	prst_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
		.clk      (clk),
		.stage_en (stage_en[6:5]),
		.mode     (cfg_q.mode),
		.adk_s5   (adk_s5),
		.akh_s5   (akh_s5),
		.akl_s5   (akl_s5),
		.base_s5  (base_s5),
		.moved_s7 (moved_s7),
		.sat_s7   (sat_s7)
	);

	assign moved_x   = moved_s7[0];
	assign moved_y   = moved_s7[1];
	assign moved_z   = moved_s7[2];
	assign saturated = sat_s7;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	logic [2:0] at_rail;

	assign at_rail[0] = (moved_x[W-2:0] == '1 && moved_x[FW-1:W-1] == '0) ||
	                    (moved_x[W-2:0] == '0 && moved_x[FW-1:W-1] == '1);
	assign at_rail[1] = (moved_y[W-2:0] == '1 && moved_y[FW-1:W-1] == '0) ||
	                    (moved_y[W-2:0] == '0 && moved_y[FW-1:W-1] == '1);
	assign at_rail[2] = (moved_z[W-2:0] == '1 && moved_z[FW-1:W-1] == '0) ||
	                    (moved_z[W-2:0] == '0 && moved_z[FW-1:W-1] == '1);

	// input stalls only when the output stage holds a point and the receiver holds off
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled while the pipeline had room");

	// a clamped result has at least one coordinate on a rail
	a_sat_on_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |-> (at_rail != 3'b000))
		else $error("saturated flag set with no coordinate at a rail");

	// results stay inside the signed coordinate range, sign extended
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			((moved_x[FW-1:W-1] == '0) || (moved_x[FW-1:W-1] == '1)) &&
			((moved_y[FW-1:W-1] == '0) || (moved_y[FW-1:W-1] == '1)) &&
			((moved_z[FW-1:W-1] == '0) || (moved_z[FW-1:W-1] == '1)))
		else $error("result outside the coordinate range");

endmodule

FILE: dv/prst_result_check.sv
// Result checker for the point rotate/scale/translate core: tracks register
// writes, predicts each moved point and compares it with the output channel.
// Depends on prst_pkg.
module prst_result_check #(
	parameter int COORD_WIDTH = 21
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [prst_pkg::CFG_IDX_W-1:0] cfg_wr_idx,
	input  logic [prst_pkg::PACK_W-1:0]    cfg_wr_data,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [prst_pkg::FIELD_W-1:0]   point_x,
	input  logic [prst_pkg::FIELD_W-1:0]   point_y,
	input  logic [prst_pkg::FIELD_W-1:0]   point_z,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [prst_pkg::FIELD_W-1:0]   moved_x,
	input  logic [prst_pkg::FIELD_W-1:0]   moved_y,
	input  logic [prst_pkg::FIELD_W-1:0]   moved_z,
	input  logic                           saturated,
	output int                             mismatches,
	output int                             in_flight,
	output int                             results_seen,
	output int                             clamped_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [prst_pkg::FIELD_W-1:0] x;
		logic [prst_pkg::FIELD_W-1:0] y;
		logic [prst_pkg::FIELD_W-1:0] z;
		logic                         sat;
	} moved_point_t;

	prst_pkg::mode_t               mode_q;
	logic [prst_pkg::PACK_W-1:0]   pivot_q;
	logic [prst_pkg::PACK_W-1:0]   axis_q;
	logic [prst_pkg::PACK_W-1:0]   offset_q;
	logic [prst_pkg::TRIG_W-1:0]   cos_q;
	logic [prst_pkg::TRIG_W-1:0]   sin_q;
	logic [prst_pkg::FACTOR_W-1:0] factor_q;

	moved_point_t expected_moves[$];

	function automatic longint sext(logic [63:0] v, int w);
		longint t;
		t = longint'(v << (64 - w));
		return t >>> (64 - w);
	endfunction

	// slot 0 is x at the top of the packed word
	function automatic longint unpack_slot(logic [prst_pkg::PACK_W-1:0] packed_v,
			int idx, int w);
		return sext(64'(packed_v >> ((2 - idx) * prst_pkg::SLOT_W)), w);
	endfunction

	function automatic moved_point_t move_point(logic [prst_pkg::FIELD_W-1:0] px, py, pz);
		longint pt[3], pv[3], ax[3], off[3], res[3], cr[3];
		longint cs, sn, fac, dot, dk, gain, hi, lo;
		moved_point_t m;
		pt[0] = sext(64'(px), COORD_WIDTH);
		pt[1] = sext(64'(py), COORD_WIDTH);
		pt[2] = sext(64'(pz), COORD_WIDTH);
		cs = sext(64'(cos_q), prst_pkg::TRIG_W);
		sn = sext(64'(sin_q), prst_pkg::TRIG_W);
		fac = longint'(factor_q);
		for (int i = 0; i < 3; i++) begin
			pv[i] = unpack_slot(pivot_q, i, COORD_WIDTH);
			ax[i] = unpack_slot(axis_q, i, prst_pkg::SLOT_W);
			off[i] = pt[i] - pv[i];
		end
		case (mode_q)
			prst_pkg::MODE_TRANSLATE: begin
				for (int i = 0; i < 3; i++)
					res[i] = pt[i] + unpack_slot(offset_q, i, COORD_WIDTH);
			end
			prst_pkg::MODE_UNI_SCALE: begin
				for (int i = 0; i < 3; i++)
					res[i] = pv[i] + ((off[i] * fac) >>> prst_pkg::FACTOR_FRAC);
			end
			default: begin
				// projection of the offset on the axis, shared by both axis modes
				dot = (ax[0] * off[0] + ax[1] * off[1] + ax[2] * off[2])
					>>> prst_pkg::AXIS_FRAC;
				if (mode_q == prst_pkg::MODE_ROTATE) begin
					dk = (dot * ((64'sd1 <<< prst_pkg::AXIS_FRAC) - cs))
						>>> prst_pkg::AXIS_FRAC;
					cr[0] = (ax[1] * off[2] - ax[2] * off[1]) >>> prst_pkg::AXIS_FRAC;
					cr[1] = (ax[2] * off[0] - ax[0] * off[2]) >>> prst_pkg::AXIS_FRAC;
					cr[2] = (ax[0] * off[1] - ax[1] * off[0]) >>> prst_pkg::AXIS_FRAC;
					for (int i = 0; i < 3; i++)
						res[i] = pv[i] + ((off[i] * cs) >>> prst_pkg::AXIS_FRAC)
							+ ((cr[i] * sn) >>> prst_pkg::AXIS_FRAC)
							+ ((ax[i] * dk) >>> prst_pkg::AXIS_FRAC);
				end else begin
					gain = (dot * (fac - (64'sd1 <<< prst_pkg::FACTOR_FRAC)))
						>>> prst_pkg::FACTOR_FRAC;
					for (int i = 0; i < 3; i++)
						res[i] = pv[i] + off[i]
							+ ((ax[i] * gain) >>> prst_pkg::AXIS_FRAC);
				end
			end
		endcase
		hi = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
		lo = -(64'sd1 <<< (COORD_WIDTH - 1));
		m.sat = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (res[i] > hi) begin
				res[i] = hi;
				m.sat = 1'b1;
			end
			if (res[i] < lo) begin
				res[i] = lo;
				m.sat = 1'b1;
			end
		end
		m.x = res[0][prst_pkg::FIELD_W-1:0];
		m.y = res[1][prst_pkg::FIELD_W-1:0];
		m.z = res[2][prst_pkg::FIELD_W-1:0];
		return m;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		moved_point_t seen;
		moved_point_t want;
		if (!arst_n) begin
			mode_q = prst_pkg::MODE_TRANSLATE;
			pivot_q = '0;
			axis_q = prst_pkg::AXIS_RESET;
			offset_q = '0;
			cos_q = prst_pkg::COS_RESET;
			sin_q = '0;
			factor_q = prst_pkg::FACTOR_RESET;
			expected_moves.delete();
			mismatches = 0;
			results_seen = 0;
			clamped_seen = 0;
		end else begin
			// retire the oldest prediction before queuing a new one
			if (out_valid && out_ready) begin
				seen = '{x: moved_x, y: moved_y, z: moved_z, sat: saturated};
				results_seen++;
				if (seen.sat)
					clamped_seen++;
				if (expected_moves.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("%0t: unexpected result x=%h y=%h z=%h sat=%b",
							$realtime, seen.x, seen.y, seen.z, seen.sat);
					mismatches++;
				end else begin
					want = expected_moves.pop_front();
					if (seen.x != want.x || seen.y != want.y || seen.z != want.z
							|| seen.sat != want.sat) begin
						if (mismatches < REPORT_LIMIT)
							$display("%0t: result mismatch exp x=%h y=%h z=%h sat=%b,",
								$realtime, want.x, want.y, want.z, want.sat,
								" got x=%h y=%h z=%h sat=%b",
								seen.x, seen.y, seen.z, seen.sat);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_moves = {expected_moves, move_point(point_x, point_y, point_z)};
			// unknown indexes fall through and leave every register alone
			if (cfg_wr_en) begin
				case (cfg_wr_idx)
					prst_pkg::REG_MODE:   mode_q = prst_pkg::mode_t'(cfg_wr_data[1:0]);
					prst_pkg::REG_PIVOT:  pivot_q = cfg_wr_data;
					prst_pkg::REG_AXIS:   axis_q = cfg_wr_data;
					prst_pkg::REG_OFFSET: offset_q = cfg_wr_data;
					prst_pkg::REG_COSINE: cos_q = cfg_wr_data[prst_pkg::TRIG_W-1:0];
					prst_pkg::REG_SINE:   sin_q = cfg_wr_data[prst_pkg::TRIG_W-1:0];
					prst_pkg::REG_FACTOR: factor_q = cfg_wr_data[prst_pkg::FACTOR_W-1:0];
					default: ;
				endcase
			end
		end
		in_flight = expected_moves.size();
	end

endmodule

FILE: dv/point_rotate_scale_translate_core_tb.sv
// Top of the point rotate/scale/translate core testbench: clock, reset,
// register setups and point stimulus, plus the verdict.
// Depends on prst_pkg, prst_result_check and the core itself.
module point_rotate_scale_translate_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_WIDTH   = 21;
	localparam int RANDOM_POINTS = 480;
	localparam int CYCLE_LIMIT   = 400000;

	// index past the register list: writes to it must be dropped
	localparam logic [prst_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	localparam logic [prst_pkg::FIELD_W-1:0] COORD_MAX   = 21'h0FFFFF;
	localparam logic [prst_pkg::FIELD_W-1:0] COORD_MIN   = 21'h100000;
	localparam logic [prst_pkg::TRIG_W-1:0]  Q19_ONE     = 21'h080000;
	localparam logic [prst_pkg::TRIG_W-1:0]  Q19_NEG_ONE = 21'h180000;

	// receiver stall styles, each held for a random span of cycles
	typedef enum int {
		DRAIN_FREE,
		DRAIN_COIN,
		DRAIN_SPARSE,
		DRAIN_CYCLIC
	} drain_style_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_wr_en = 1'b0;
	logic [prst_pkg::CFG_IDX_W-1:0] cfg_wr_idx = prst_pkg::REG_MODE;
	logic [prst_pkg::PACK_W-1:0]    cfg_wr_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [prst_pkg::FIELD_W-1:0]   point_x = '0;
	logic [prst_pkg::FIELD_W-1:0]   point_y = '0;
	logic [prst_pkg::FIELD_W-1:0]   point_z = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [prst_pkg::FIELD_W-1:0]   moved_x;
	logic [prst_pkg::FIELD_W-1:0]   moved_y;
	logic [prst_pkg::FIELD_W-1:0]   moved_z;
	logic                           saturated;

	int mismatches;
	int in_flight;
	int results_seen;
	int clamped_seen;

	int cycle_count = 0;
	int burst_left = 0;
	int points_sent = 0;
	int setups_applied = 0;

	point_rotate_scale_translate_core #(
		.COORD_WIDTH(COORD_WIDTH)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_idx (cfg_wr_idx),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_z    (point_z),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.moved_x    (moved_x),
		.moved_y    (moved_y),
		.moved_z    (moved_z),
		.saturated  (saturated)
	);

	prst_result_check #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_idx  (cfg_wr_idx),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.moved_x     (moved_x),
		.moved_y     (moved_y),
		.moved_z     (moved_z),
		.saturated   (saturated),
		.mismatches  (mismatches),
		.in_flight   (in_flight),
		.results_seen(results_seen),
		.clamped_seen(clamped_seen)
	);

	always #1 clk = ~clk;

	// Hard stop: the slowest legal run stays far below this many cycles.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL point_rotate_scale_translate_core");
			$finish;
		end
	end

	// Receiver: pick a stall style, hold it for a while, then switch. Free
	// spans give long stretches with no back-pressure at all.
	initial begin : drain
		drain_style_t style;
		int span;
		int tick;
		tick = 0;
		forever begin
			style = drain_style_t'($urandom_range(0, 3));
			span = $urandom_range(8, 64);
			repeat (span) begin
				@(negedge clk);
				tick++;
				case (style)
					DRAIN_FREE:   out_ready <= 1'b1;
					DRAIN_COIN:   out_ready <= 1'($urandom_range(0, 1));
					DRAIN_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default:      out_ready <= ((tick % 5) < 2);
				endcase
			end
		end
	end

	function automatic logic [prst_pkg::PACK_W-1:0] pack3(
			logic [prst_pkg::SLOT_W-1:0] x, y, z);
		return {x, y, z};
	endfunction

	// Small coordinates in three draws of eight so the transforms stay in range;
	// extremes and full-width values drive saturation and toggle every bit.
	function automatic logic [prst_pkg::FIELD_W-1:0] rand_coord();
		case ($urandom_range(0, 7))
			0:       return COORD_MAX;
			1:       return COORD_MIN;
			2:       return '0;
			3, 4, 5: return prst_pkg::FIELD_W'(int'($urandom_range(0, 32767)) - 16384);
			default: return prst_pkg::FIELD_W'($urandom);
		endcase
	endfunction

	// values within roughly plus or minus 0.7 in Q1.19, used for random axis components
	function automatic logic [prst_pkg::TRIG_W-1:0] rand_q19();
		return prst_pkg::TRIG_W'(int'($urandom_range(0, 740000)) - 370000);
	endfunction

	// One register write per call; the trailing idle cycle keeps the enable
	// from being lowered and raised again in the same step.
	task automatic write_reg(input logic [prst_pkg::CFG_IDX_W-1:0] idx,
			input logic [prst_pkg::PACK_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_wr_idx <= idx;
		cfg_wr_data <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Send one point. Between bursts, drop valid for a random gap; a zero gap
	// merges two bursts into one unbroken stream.
	task automatic push_point(input logic [prst_pkg::FIELD_W-1:0] x, y, z);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		burst_left--;
		in_valid <= 1'b1;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		// hold the transaction until the core takes it
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		points_sent++;
	endtask

	// Drain the pipeline before touching the registers or ending the run.
	task automatic settle();
		in_valid <= 1'b0;
		while (in_flight != 0)
			@(negedge clk);
		repeat (prst_pkg::NUM_STAGES + 2) @(negedge clk);
	endtask

	task automatic send_corner_points();
		push_point(COORD_MAX, COORD_MAX, COORD_MAX);
		push_point(COORD_MIN, COORD_MIN, COORD_MIN);
		push_point('0, COORD_MAX, COORD_MIN);
		push_point(21'd1024, prst_pkg::FIELD_W'(-1024), 21'd1);
	endtask

	// New random setup: the mode every time, the other registers most of the
	// time, with extremes and out-of-range trig values mixed in.
	task automatic pick_random_setup();
		prst_pkg::mode_t mode;
		int k;
		real ang;
		logic [prst_pkg::PACK_W-1:0] ax;
		logic [prst_pkg::TRIG_W-1:0] cs;
		logic [prst_pkg::TRIG_W-1:0] sn;
		logic [prst_pkg::FACTOR_W-1:0] fac;
		mode = prst_pkg::mode_t'($urandom_range(0, 3));
		write_reg(prst_pkg::REG_MODE, prst_pkg::PACK_W'(mode));
		if ($urandom_range(0, 3) != 0)
			write_reg(prst_pkg::REG_PIVOT, pack3(rand_coord(), rand_coord(), rand_coord()));
		if ($urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 3))
				0: begin
					k = $urandom_range(0, 2);
					ax = prst_pkg::PACK_W'($urandom_range(0, 1) ? Q19_NEG_ONE : Q19_ONE)
						<< (k * prst_pkg::SLOT_W);
				end
				1:       ax = pack3(rand_q19(), rand_q19(), rand_q19());
				2:       ax = prst_pkg::PACK_W'({$urandom, $urandom});
				default: ax = pack3(21'd314573, prst_pkg::FIELD_W'(-419430), '0);
			endcase
			write_reg(prst_pkg::REG_AXIS, ax);
		end
		if ($urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 3))
				0: begin
					// quarter turns land exactly on plus or minus one
					case ($urandom_range(0, 3))
						0: begin
							cs = Q19_ONE;
							sn = '0;
						end
						1: begin
							cs = '0;
							sn = Q19_ONE;
						end
						2: begin
							cs = Q19_NEG_ONE;
							sn = '0;
						end
						default: begin
							cs = '0;
							sn = Q19_NEG_ONE;
						end
					endcase
				end
				1, 2: begin
					ang = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
					cs = prst_pkg::TRIG_W'($rtoi($cos(ang) * 524288.0));
					sn = prst_pkg::TRIG_W'($rtoi($sin(ang) * 524288.0));
				end
				default: begin
					cs = prst_pkg::TRIG_W'($urandom);
					sn = prst_pkg::TRIG_W'($urandom);
				end
			endcase
			write_reg(prst_pkg::REG_COSINE, prst_pkg::PACK_W'(cs));
			write_reg(prst_pkg::REG_SINE, prst_pkg::PACK_W'(sn));
		end
		if ($urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 7))
				0:       fac = '0;
				1:       fac = 20'd1;
				2:       fac = prst_pkg::FACTOR_RESET;
				3:       fac = 20'hFFFFF;
				4, 5:    fac = prst_pkg::FACTOR_W'($urandom_range(1024, 16384));
				default: fac = prst_pkg::FACTOR_W'($urandom);
			endcase
			write_reg(prst_pkg::REG_FACTOR, prst_pkg::PACK_W'(fac));
		end
		if ($urandom_range(0, 3) != 0)
			write_reg(prst_pkg::REG_OFFSET, pack3(rand_coord(), rand_coord(), rand_coord()));
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_UNUSED, prst_pkg::PACK_W'({$urandom, $urandom}));
		setups_applied++;
	endtask

	initial begin : stimulus
		int random_sent;
		int run_len;
		random_sent = 0;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Reset setup: translate by zero, so every point comes back unchanged.
		send_corner_points();
		settle();

		// Translate by extreme offsets: clamps high on x, low on y.
		write_reg(prst_pkg::REG_OFFSET, pack3(COORD_MAX, COORD_MIN, 21'd1024));
		setups_applied++;
		send_corner_points();
		settle();

		// Quarter turn about z through an off-center pivot.
		write_reg(prst_pkg::REG_MODE, prst_pkg::PACK_W'(prst_pkg::MODE_ROTATE));
		write_reg(prst_pkg::REG_PIVOT,
			pack3(21'd1024, 21'd2048, prst_pkg::FIELD_W'(-512)));
		write_reg(prst_pkg::REG_COSINE, prst_pkg::PACK_W'(prst_pkg::TRIG_W'(0)));
		write_reg(prst_pkg::REG_SINE, prst_pkg::PACK_W'(Q19_ONE));
		setups_applied++;
		send_corner_points();
		settle();

		// Non-unit axis with cosine and sine past plus and minus one: used as given.
		write_reg(prst_pkg::REG_AXIS, pack3(COORD_MAX, COORD_MAX, COORD_MAX));
		write_reg(prst_pkg::REG_COSINE, prst_pkg::PACK_W'(prst_pkg::TRIG_W'(21'h0FFFFF)));
		write_reg(prst_pkg::REG_SINE, prst_pkg::PACK_W'(prst_pkg::TRIG_W'(21'h100000)));
		setups_applied++;
		send_corner_points();
		settle();

		// Zero factor collapses onto the pivot; the stray index must change nothing.
		write_reg(prst_pkg::REG_MODE, prst_pkg::PACK_W'(prst_pkg::MODE_UNI_SCALE));
		write_reg(prst_pkg::REG_FACTOR, '0);
		write_reg(REG_UNUSED, {prst_pkg::PACK_W{1'b1}});
		setups_applied++;
		send_corner_points();
		settle();

		// Largest factor along a unit x axis.
		write_reg(prst_pkg::REG_MODE, prst_pkg::PACK_W'(prst_pkg::MODE_AXIS_SCALE));
		write_reg(prst_pkg::REG_AXIS, pack3(Q19_ONE, '0, '0));
		write_reg(prst_pkg::REG_FACTOR, prst_pkg::PACK_W'(20'hFFFFF));
		setups_applied++;
		send_corner_points();
		settle();

		// Random setups, each followed by a run of random points.
		while (random_sent < RANDOM_POINTS) begin
			pick_random_setup();
			run_len = $urandom_range(20, 40);
			repeat (run_len) begin
				push_point(rand_coord(), rand_coord(), rand_coord());
				random_sent++;
			end
			settle();
		end

		$display("Run covered %0d points over %0d register setups in all four modes.",
			points_sent, setups_applied);
		$display("Checked %0d results, %0d of them clamped, %0d mismatches.",
			results_seen, clamped_seen, mismatches);
		if (mismatches == 0) begin
			$display("PASS point_rotate_scale_translate_core");
		end else begin
			$display("FAIL point_rotate_scale_translate_core");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/prst_pkg.sv
rtl/prst_flow.sv
rtl/prst_front.sv
rtl/prst_mid.sv
rtl/prst_back.sv
rtl/point_rotate_scale_translate_core.sv
dv/prst_result_check.sv
dv/point_rotate_scale_translate_core_tb.sv
